>>> hdl/srdu_pkg.sv
// Shared types and constants of the segmented reduction unit.
`timescale 1ns / 1ps
package srdu_pkg;

   localparam int OP_W    = 3;
   localparam int LEN_W   = 16;
   localparam int CSR_W   = 16;
   localparam int CIDX_W  = 2;

   // Fold operations
   localparam logic [OP_W-1:0] OP_SUM  = 3'd0;
   localparam logic [OP_W-1:0] OP_MEAN = 3'd1;
   localparam logic [OP_W-1:0] OP_PROD = 3'd2;
   localparam logic [OP_W-1:0] OP_MAX  = 3'd3;
   localparam logic [OP_W-1:0] OP_MIN  = 3'd4;
   localparam logic [OP_W-1:0] OP_ANY  = 3'd5;

   // Configuration register indexes
   localparam logic [CIDX_W-1:0] CSR_OP_MODE        = 2'd0;
   localparam logic [CIDX_W-1:0] CSR_SEGMENT_LENGTH = 2'd1;
   localparam logic [CIDX_W-1:0] CSR_CHUNK_COUNT    = 2'd2;

   // Segment queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      logic [OP_W-1:0]  op_mode;
      logic [LEN_W-1:0] segment_length;
      logic [LEN_W-1:0] chunk_count;
   } cfg_type;

   typedef struct packed {
      logic             is_mean;
      logic [LEN_W-1:0] seg_len;
      logic             last;
   } seg_ctrl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

>>> hdl/segmented_reduction_unit.sv
// Top level of the segmented reduction unit.
// Usage:
//   Elements enter on push/full (req_element_value); one is accepted at each
//   edge with push high and full low. Every segment_length elements form one
//   segment, folded by op_mode (sum, mean, product, max, min, any).
//   One request leaves per segment on empty/pop with rsp_reduced_value and
//   rsp_is_last_chunk, set on every chunk_count-th result. Configuration
//   is written over csr_valid/csr_ready (always ready) with csr_index and
//   csr_data; the user must do so only while the unit is idle (not enforced).
// Timing:
//   The front folds one element per cycle while full is low. A segment
//   result enters a four-deep queue at the edge that takes its last
//   element; the back moves a non-mean result from the queue into the
//   result register once that register is free. A mean runs a
//   one-bit-per-cycle restoring divider, then enters the result register;
//   the divider starts the next mean only after the last one has left it.
// Reset clears counters, queue and result register; registers return to
// sum, segment length 1 and chunk count 1. With pop held low the result
// register holds, the queue fills, and full rises only on an element that
// would close a segment while the queue is full.
`timescale 1ns / 1ps
module segmented_reduction_unit #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic signed [DATA_WIDTH-1:0] req_element_value,
   output logic                         empty,
   input  logic                         pop,
   output logic signed [DATA_WIDTH-1:0] rsp_reduced_value,
   output logic                         rsp_is_last_chunk,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [srdu_pkg::CIDX_W-1:0]  csr_index,
   input  logic [srdu_pkg::CSR_W-1:0]   csr_data
);
   import srdu_pkg::*;

   localparam int ENTRY_W = DATA_WIDTH + $bits(seg_ctrl_type);

   cfg_type               cfg_ff, cfg_in;
   q_status_type          q_status;
   logic                  q_push, q_pop;
   logic [DATA_WIDTH-1:0] f_value, b_value, rsp_value;
   seg_ctrl_type          f_ctrl, b_ctrl;
   logic [ENTRY_W-1:0]    q_rd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_OP_MODE:        cfg_in.op_mode        = csr_data[OP_W-1:0];
            CSR_SEGMENT_LENGTH: cfg_in.segment_length = csr_data[LEN_W-1:0];
            CSR_CHUNK_COUNT:    cfg_in.chunk_count    = csr_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.op_mode        <= OP_SUM;
         cfg_ff.segment_length <= LEN_W'(1);
         cfg_ff.chunk_count    <= LEN_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   srdu_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .push     (push),
      .full     (full),
      .element  (req_element_value),
      .q_status (q_status),
      .q_push   (q_push),
      .q_value  (f_value),
      .q_ctrl   (f_ctrl)
   );

   srdu_queue #(.WIDTH(ENTRY_W)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data ({f_value, f_ctrl}),
      .rd_en   (q_pop),
      .rd_data (q_rd_data),
      .status  (q_status)
   );

   assign b_value = q_rd_data[ENTRY_W-1 -: DATA_WIDTH];
   assign b_ctrl  = q_rd_data[$bits(seg_ctrl_type)-1:0];

   srdu_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_pop     (q_pop),
      .q_value   (b_value),
      .q_ctrl    (b_ctrl),
      .pop       (pop),
      .empty     (empty),
      .rsp_value (rsp_value),
      .rsp_last  (rsp_is_last_chunk)
   );

   assign rsp_reduced_value = rsp_value;

   // full is only ever raised by a full queue
   a_full_needs_queue: assert property (@(posedge clock) disable iff (reset)
      full |-> q_status.full)
      else $error("full raised with room in the segment queue");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_status.full))
      else $error("segment queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_status.empty))
      else $error("segment queue underflow");

   // a non-mean segment goes straight into the result register
   a_direct_result: assert property (@(posedge clock) disable iff (reset)
      (q_pop && !b_ctrl.is_mean) |=> !empty)
      else $error("dequeued result did not reach the output");

endmodule

>>> hdl/srdu_front.sv
// Front end: takes elements, folds each segment and counts chunks.
`timescale 1ns / 1ps
module srdu_front #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  srdu_pkg::cfg_type        cfg,
   input  logic                     push,
   output logic                     full,
   input  logic [DATA_WIDTH-1:0]    element,
   input  srdu_pkg::q_status_type   q_status,
   output logic                     q_push,
   output logic [DATA_WIDTH-1:0]    q_value,
   output srdu_pkg::seg_ctrl_type   q_ctrl
);
   import srdu_pkg::*;

   logic [DATA_WIDTH-1:0] acc_ff, acc_in;
   logic [LEN_W-1:0]      elem_idx_ff, elem_idx_in;
   logic [LEN_W-1:0]      chunk_idx_ff, chunk_idx_in;
   logic [LEN_W-1:0]      len_eff, cnt_eff;
   logic                  seg_end, tensor_end, accept;
   logic [DATA_WIDTH-1:0] fold, prod;

   assign len_eff    = (cfg.segment_length == '0) ? LEN_W'(1) : cfg.segment_length;
   assign cnt_eff    = (cfg.chunk_count == '0) ? LEN_W'(1) : cfg.chunk_count;
   assign seg_end    = ({1'b0, elem_idx_ff} + 17'd1) >= {1'b0, len_eff};
   assign tensor_end = ({1'b0, chunk_idx_ff} + 17'd1) >= {1'b0, cnt_eff};

   // only an item that closes a segment needs room in the queue
   assign full   = seg_end & q_status.full;
   assign accept = push & ~full;

   assign prod = acc_ff * element;

   always_comb begin
      if (elem_idx_ff == '0) begin
         fold = element;
      end else begin
         case (cfg.op_mode)
            OP_PROD: fold = prod;
            OP_MAX:  fold = ($signed(element) > $signed(acc_ff)) ? element : acc_ff;
            OP_MIN:  fold = ($signed(acc_ff) > $signed(element)) ? element : acc_ff;
            OP_ANY:  fold = ((element != '0) || (acc_ff != '0)) ?
                            DATA_WIDTH'(1) : '0;
            default: fold = acc_ff + element;
         endcase
      end
   end

   always_comb begin
      acc_in       = acc_ff;
      elem_idx_in  = elem_idx_ff;
      chunk_idx_in = chunk_idx_ff;
      if (accept) begin
         acc_in = fold;
         if (seg_end) begin
            elem_idx_in  = '0;
            chunk_idx_in = tensor_end ? '0 : chunk_idx_ff + LEN_W'(1);
         end else begin
            elem_idx_in = elem_idx_ff + LEN_W'(1);
         end
      end
   end

   assign q_push         = accept & seg_end;
   assign q_value        = fold;
   assign q_ctrl.is_mean = (cfg.op_mode == OP_MEAN);
   assign q_ctrl.seg_len = len_eff;
   assign q_ctrl.last    = tensor_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         elem_idx_ff  <= '0;
         chunk_idx_ff <= '0;
      end else begin
         acc_ff       <= acc_in;
         elem_idx_ff  <= elem_idx_in;
         chunk_idx_ff <= chunk_idx_in;
      end
   end

endmodule

>>> hdl/srdu_queue.sv
// Short queue of finished segments between front and back.
`timescale 1ns / 1ps
module srdu_queue #(
   parameter int WIDTH = 50
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [WIDTH-1:0]       wr_data,
   input  logic                   rd_en,
   output logic [WIDTH-1:0]       rd_data,
   output srdu_pkg::q_status_type status
);
   import srdu_pkg::*;

   logic [WIDTH-1:0]  slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign rd_data      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(wr_en) - QCNT_W'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hdl/srdu_back.sv
// Back end: serial divider for the mean and the result register.
`timescale 1ns / 1ps
module srdu_back #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  srdu_pkg::q_status_type q_status,
   output logic                   q_pop,
   input  logic [DATA_WIDTH-1:0]  q_value,
   input  srdu_pkg::seg_ctrl_type q_ctrl,
   input  logic                   pop,
   output logic                   empty,
   output logic [DATA_WIDTH-1:0]  rsp_value,
   output logic                   rsp_last
);
   import srdu_pkg::*;

   localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

   typedef enum logic [2:0] {
      BK_IDLE = 3'b001,
      BK_DIV  = 3'b010,
      BK_DONE = 3'b100
   } back_state_type;

   back_state_type        state_ff, state_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [LEN_W-1:0]      rem_ff, rem_in;
   logic [LEN_W-1:0]      div_len_ff, div_len_in;
   logic                  div_neg_ff, div_neg_in;
   logic                  div_last_ff, div_last_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  out_valid_ff, out_valid_in;
   logic [DATA_WIDTH-1:0] out_value_ff, out_value_in;
   logic                  out_last_ff, out_last_in;
   logic                  slot_free;
   logic [LEN_W:0]        shifted, diff;
   logic                  ge;
   logic [DATA_WIDTH-1:0] mag;

   assign slot_free = ~out_valid_ff | pop;
   assign shifted   = {rem_ff, quo_ff[DATA_WIDTH-1]};
   assign ge        = shifted >= {1'b0, div_len_ff};
   assign diff      = shifted - {1'b0, div_len_ff};
   assign mag       = q_value[DATA_WIDTH-1] ? (~q_value + DATA_WIDTH'(1)) : q_value;

   always_comb begin
      state_in     = state_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_len_in   = div_len_ff;
      div_neg_in   = div_neg_ff;
      div_last_in  = div_last_ff;
      cnt_in       = cnt_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff & ~pop;
      q_pop        = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               if (q_ctrl.is_mean) begin
                  // start a restoring division of the magnitude
                  q_pop       = 1'b1;
                  quo_in      = mag;
                  rem_in      = '0;
                  div_len_in  = q_ctrl.seg_len;
                  div_neg_in  = q_value[DATA_WIDTH-1];
                  div_last_in = q_ctrl.last;
                  cnt_in      = CNT_W'(DATA_WIDTH - 1);
                  state_in    = BK_DIV;
               end else if (slot_free) begin
                  q_pop        = 1'b1;
                  out_valid_in = 1'b1;
                  out_value_in = q_value;
                  out_last_in  = q_ctrl.last;
               end
            end
         end
         BK_DIV: begin
            rem_in = ge ? diff[LEN_W-1:0] : shifted[LEN_W-1:0];
            quo_in = {quo_ff[DATA_WIDTH-2:0], ge};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_value_in = div_neg_ff ? (~quo_ff + DATA_WIDTH'(1)) : quo_ff;
               out_last_in  = div_last_ff;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   assign empty     = ~out_valid_ff;
   assign rsp_value = out_value_ff;
   assign rsp_last  = out_last_ff;

   always_ff @(posedge clock) begin
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      div_len_ff   <= div_len_in;
      div_neg_ff   <= div_neg_in;
      div_last_ff  <= div_last_in;
      cnt_ff       <= cnt_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
